/* rtl/ssps_pkg.sv */
// shared types and constants for the state space predict step block
// opcodes, sequencer states and default sizes; no dependencies
package ssps_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 4;

	localparam int STATE_SIZE_DEF = 4;
	localparam int DRIVE_SIZE_DEF = 4;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic [1:0] {
		OP_LOAD_F = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_SET_X  = 2'd2,
		OP_DRIVE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} st_t;

endpackage

/* rtl/state_space_predict_step.sv */
// x := F*x + B*u in signed fixed point, one multiply-accumulate per cycle while a row is issued
// a write item is taken while idle; a drive item with last starts an update that, per
// row, issues each F entry and then each B entry of that row, one per cycle, then drains
// the pipeline and emits the row once the output register is free or being read
// results leave through an output register, one per row; input is stalled during update
// reset clears F, B (through per-entry valid bits), x, u and all control state
module state_space_predict_step #(
	parameter int STATE_SIZE = ssps_pkg::STATE_SIZE_DEF,
	parameter int DRIVE_SIZE = ssps_pkg::DRIVE_SIZE_DEF,
	parameter int FRAC_BITS  = ssps_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           opcode,
	input  logic [ssps_pkg::IDX_W-1:0]           row,
	input  logic [ssps_pkg::IDX_W-1:0]           col,
	input  logic signed [ssps_pkg::DATA_W-1:0]   value,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ssps_pkg::IDX_W-1:0]           index,
	output logic signed [ssps_pkg::DATA_W-1:0]   state_value,
	output logic                                 final_res
);

	localparam int DW   = ssps_pkg::DATA_W;
	localparam int IW   = ssps_pkg::IDX_W;
	localparam int FN   = STATE_SIZE * STATE_SIZE;
	localparam int BN   = STATE_SIZE * DRIVE_SIZE;
	localparam int FAW  = (FN > 1) ? $clog2(FN) : 1;
	localparam int BAW  = (BN > 1) ? $clog2(BN) : 1;
	localparam int XW   = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;
	localparam int UW   = (DRIVE_SIZE > 1) ? $clog2(DRIVE_SIZE) : 1;
	localparam int PW   = 2 * DW;
	localparam int RW   = PW + 1 - FRAC_BITS;
	localparam int AW   = RW + $clog2(STATE_SIZE + DRIVE_SIZE) + 1;
	localparam logic signed [AW-1:0] SAT_HI = AW'(64'sh0000_0000_7fff_ffff);
	localparam logic signed [AW-1:0] SAT_LO = AW'(-64'sh0000_0000_8000_0000);
	localparam logic signed [PW:0]   RND_HALF = (PW+1)'(1) <<< (FRAC_BITS - 1);

	ssps_pkg::st_t state_q, state_nxt;
	ssps_pkg::op_t op;

	logic in_xfer, out_xfer, start, issue, emit_go, row_last;

	// coefficient memories with per-entry valid bits standing in for the zero reset
	logic signed [DW-1:0] f_mem [FN];
	logic signed [DW-1:0] b_mem [BN];
	logic [FN-1:0]        f_vld_q;
	logic [BN-1:0]        b_vld_q;
	logic                 f_we, b_we;
	logic [FAW-1:0]       f_waddr;
	logic [BAW-1:0]       b_waddr;

	logic signed [DW-1:0] x_q   [STATE_SIZE];
	logic signed [DW-1:0] u_q   [DRIVE_SIZE];
	logic signed [DW-1:0] nxt_q [STATE_SIZE];

	// sequencer
	logic           phase_q;
	logic [IW-1:0]  idx_q;
	logic [IW-1:0]  row_q;
	logic [FAW-1:0] f_addr_q;
	logic [BAW-1:0] b_addr_q;

	// datapath pipeline
	logic                 v_s1, v_s2, v_s3;
	logic                 phase_s1, f_ok_s1, b_ok_s1;
	logic signed [DW-1:0] f_rd_s1, b_rd_s1, opnd_s1;
	logic signed [DW-1:0] coef;
	logic signed [PW-1:0] prod_s2;
	logic signed [PW:0]   psum;
	logic signed [RW-1:0] rnd_s3;
	logic signed [AW-1:0] acc_q;
	logic signed [DW-1:0] sat;

	logic                 out_valid_q, final_q;
	logic [IW-1:0]        index_q;
	logic signed [DW-1:0] value_q;

	assign op       = ssps_pkg::op_t'(opcode);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign start    = in_xfer && (op == ssps_pkg::OP_DRIVE) && last;
	assign row_last = (row_q == IW'(STATE_SIZE - 1));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ssps_pkg::ST_IDLE: begin
				if (start)
					state_nxt = ssps_pkg::ST_ISSUE;
			end
			ssps_pkg::ST_ISSUE: begin
				if (phase_q && idx_q == IW'(DRIVE_SIZE - 1))
					state_nxt = ssps_pkg::ST_DRAIN;
			end
			ssps_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3)
					state_nxt = ssps_pkg::ST_EMIT;
			end
			ssps_pkg::ST_EMIT: begin
				if (emit_go)
					state_nxt = row_last ? ssps_pkg::ST_IDLE : ssps_pkg::ST_ISSUE;
			end
			default: state_nxt = ssps_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = (state_q != ssps_pkg::ST_IDLE);
		issue    = (state_q == ssps_pkg::ST_ISSUE);
		emit_go  = (state_q == ssps_pkg::ST_EMIT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ssps_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// write decode
	always_comb begin
		f_we    = 1'b0;
		b_we    = 1'b0;
		f_waddr = FAW'(32'(row) * STATE_SIZE + 32'(col));
		b_waddr = BAW'(32'(row) * DRIVE_SIZE + 32'(col));
		if (in_xfer) begin
			unique case (op)
				ssps_pkg::OP_LOAD_F: f_we = (32'(row) < STATE_SIZE) && (32'(col) < STATE_SIZE);
				ssps_pkg::OP_LOAD_B: b_we = (32'(row) < STATE_SIZE) && (32'(col) < DRIVE_SIZE);
				ssps_pkg::OP_SET_X:  ;
				ssps_pkg::OP_DRIVE:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (f_we)
			f_mem[f_waddr] <= value;
		f_rd_s1 <= f_mem[f_addr_q];
	end

	always_ff @(posedge clk) begin
		if (b_we)
			b_mem[b_waddr] <= value;
		b_rd_s1 <= b_mem[b_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_vld_q <= '0;
			b_vld_q <= '0;
		end else begin
			if (f_we)
				f_vld_q[f_waddr] <= 1'b1;
			if (b_we)
				b_vld_q[b_waddr] <= 1'b1;
		end
	end

	// state and drive vectors; new state commits when the last row is sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STATE_SIZE; i++)
				x_q[i] <= '0;
			for (int i = 0; i < DRIVE_SIZE; i++)
				u_q[i] <= '0;
		end else begin
			if (in_xfer && op == ssps_pkg::OP_SET_X && 32'(row) < STATE_SIZE)
				x_q[row[XW-1:0]] <= value;
			if (in_xfer && op == ssps_pkg::OP_DRIVE && 32'(row) < DRIVE_SIZE)
				u_q[row[UW-1:0]] <= value;
			if (emit_go && row_last) begin
				for (int i = 0; i < STATE_SIZE; i++)
					x_q[i] <= (i == STATE_SIZE - 1) ? sat : nxt_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go)
			nxt_q[row_q[XW-1:0]] <= sat;
	end

	// issue counters walk F then B row major, so addresses just count up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			idx_q    <= '0;
			row_q    <= '0;
			f_addr_q <= '0;
			b_addr_q <= '0;
		end else begin
			if (start) begin
				phase_q  <= 1'b0;
				idx_q    <= '0;
				row_q    <= '0;
				f_addr_q <= '0;
				b_addr_q <= '0;
			end else if (issue) begin
				if (!phase_q) begin
					f_addr_q <= f_addr_q + 1'b1;
					if (idx_q == IW'(STATE_SIZE - 1)) begin
						phase_q <= 1'b1;
						idx_q   <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end else begin
					b_addr_q <= b_addr_q + 1'b1;
					if (idx_q != IW'(DRIVE_SIZE - 1))
						idx_q <= idx_q + 1'b1;
				end
			end else if (emit_go) begin
				phase_q <= 1'b0;
				idx_q   <= '0;
				row_q   <= row_q + 1'b1;
			end
		end
	end

	// datapath control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		phase_s1 <= phase_q;
		f_ok_s1  <= f_vld_q[f_addr_q];
		b_ok_s1  <= b_vld_q[b_addr_q];
		opnd_s1  <= phase_q ? u_q[idx_q[UW-1:0]] : x_q[idx_q[XW-1:0]];
	end

	// never written entries read as zero
	always_comb begin
		if (phase_s1)
			coef = b_ok_s1 ? b_rd_s1 : '0;
		else
			coef = f_ok_s1 ? f_rd_s1 : '0;
	end

	assign psum = {prod_s2[PW-1], prod_s2} + RND_HALF;

	always_ff @(posedge clk) begin
		prod_s2 <= coef * opnd_s1;
		rnd_s3  <= psum[PW:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (emit_go || start)
			acc_q <= '0;
		else if (v_s3)
			acc_q <= acc_q + {{(AW-RW){rnd_s3[RW-1]}}, rnd_s3};
	end

	always_comb begin
		if (acc_q > SAT_HI)
			sat = SAT_HI[DW-1:0];
		else if (acc_q < SAT_LO)
			sat = SAT_LO[DW-1:0];
		else
			sat = acc_q[DW-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_go)
			out_valid_q <= 1'b1;
		else if (out_xfer)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			index_q <= row_q;
			value_q <= sat;
			final_q <= row_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign index       = index_q;
	assign state_value = value_q;
	assign final_res   = final_q;

endmodule
